[sv/fca_pkg.sv]
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator package
// Widths, codes and the command and status types shared by the controller
// and the datapath.
// ----------------------------------------------------------------------------
package fca_pkg;

  // Table geometry. CLUSTER_BYTES is a power of two.
  localparam int TABLE_ENTRIES = 2048;
  localparam int CLUSTER_BYTES = 512;
  localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int LIM_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int ACTION_W    = 1;
  localparam int BYTES_W     = 21;
  localparam int TARGET_W    = 11;
  localparam int ENTRY_W     = 12;
  localparam int FIRST_W     = 11;
  localparam int STATUS_W    = 2;
  localparam int FREE_W      = 11;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int SUM_W       = BYTES_W + 1;
  localparam int NEED_W      = SUM_W - CLUSTER_SHIFT;

  // Register reset values and limits.
  localparam int END_MARK_RESET = 4095;
  localparam int ACTIVE_RESET   = 2048;
  localparam int MIN_ACTIVE     = 3;
  localparam int FIRST_DATA     = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE   = 2'd1;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CLUSTER = 2'd3;

  // Datapath operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
  localparam logic [OP_W-1:0] OP_RC_INIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_RC_SCAN   = 3'd3;
  localparam logic [OP_W-1:0] OP_DECODE    = 3'd4;
  localparam logic [OP_W-1:0] OP_WR_COMMIT = 3'd5;
  localparam logic [OP_W-1:0] OP_AL_SCAN   = 3'd6;
  localparam logic [OP_W-1:0] OP_AL_FINAL  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                load;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                res_load;
  } fca_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_end;
    logic need_zero;
    logic is_write;
    logic bad_target;
    logic no_space;
    logic out_ready;
  } fca_stat_t;

endpackage

[sv/fca_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One synchronous write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/fca_dpath.sv]
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator datapath
// Holds the allocation table, the configuration registers, the scan pointer,
// the free count and the result register.
// ----------------------------------------------------------------------------
module fca_dpath import fca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [BYTES_W-1:0]     in_byte_count,
  input  logic [TARGET_W-1:0]    in_target_cluster,
  input  logic [ENTRY_W-1:0]     in_entry_value,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  fca_cmd_t               cmd,
  output fca_stat_t              stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIRST_W-1:0]     out_first_cluster,
  output logic [STATUS_W-1:0]    out_status,
  output logic [FREE_W-1:0]      out_free_clusters
);

  logic [ENTRY_W-1:0]    end_mark_r;
  logic [CFG_DATA_W-1:0] active_r;
  logic [LIM_W-1:0]      scan_addr_r;
  logic                  pend_v_r;
  logic [ADDR_W-1:0]     pend_addr_r;
  logic [ADDR_W-1:0]     free_r;
  logic                  out_valid_r;

  logic [NEED_W-1:0]     need_r;
  logic [ADDR_W-1:0]     prev_r;
  logic                  have_prev_r;
  logic [ADDR_W-1:0]     first_r;
  logic [ACTION_W-1:0]   action_r;
  logic [TARGET_W-1:0]   target_r;
  logic [ENTRY_W-1:0]    value_r;
  logic [STATUS_W-1:0]   status_r;
  logic [FIRST_W-1:0]    out_first_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [FREE_W-1:0]     out_free_r;

  logic [LIM_W-1:0]      lim;
  logic [SUM_W-1:0]      byte_sum;
  logic [NEED_W-1:0]     need_in;
  logic                  scan_issue;
  logic                  found;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  always_comb begin
    if (32'(active_r) < MIN_ACTIVE) begin
      lim = LIM_W'(MIN_ACTIVE);
    end else if (32'(active_r) > TABLE_ENTRIES) begin
      lim = LIM_W'(TABLE_ENTRIES);
    end else begin
      lim = LIM_W'(active_r);
    end
  end

  // Byte count rounded up to whole clusters.
  assign byte_sum   = SUM_W'(in_byte_count) + SUM_W'(CLUSTER_BYTES - 1);
  assign need_in    = NEED_W'(byte_sum >> CLUSTER_SHIFT);

  assign scan_issue = (scan_addr_r < lim);
  assign found      = (cmd.op == OP_AL_SCAN) && pend_v_r && (ram_rdata == '0) &&
                      (need_r != '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_addr_r[ADDR_W-1:0];
    ram_wdata = '0;
    case (cmd.op)
      OP_CLEAR: begin
        ram_we = 1'b1;
      end
      OP_WR_COMMIT: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(target_r);
        ram_wdata = value_r;
      end
      OP_AL_SCAN: begin
        ram_we    = found && have_prev_r;
        ram_waddr = prev_r;
        ram_wdata = ENTRY_W'(pend_addr_r);
      end
      OP_AL_FINAL: begin
        ram_we    = have_prev_r;
        ram_waddr = prev_r;
        ram_wdata = end_mark_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = (cmd.op == OP_DECODE) ? ADDR_W'(target_r) : scan_addr_r[ADDR_W-1:0];

  fca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_mark_r  <= ENTRY_W'(END_MARK_RESET);
      active_r    <= CFG_DATA_W'(ACTIVE_RESET);
      scan_addr_r <= '0;
      pend_v_r    <= 1'b0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_END_MARK)) begin
        end_mark_r <= ENTRY_W'(cfg_wdata);
      end
      if (cfg_we && (cfg_index == REG_ACTIVE)) begin
        active_r <= cfg_wdata;
      end
      case (cmd.op)
        OP_CLEAR: begin
          scan_addr_r <= scan_addr_r + 1'b1;
          if (stat.clr_done) begin
            free_r <= ADDR_W'(lim - LIM_W'(FIRST_DATA));
          end
        end
        OP_RC_INIT, OP_DECODE: begin
          scan_addr_r <= LIM_W'(FIRST_DATA);
          pend_v_r    <= 1'b0;
          if (cmd.op == OP_RC_INIT) begin
            free_r <= '0;
          end
        end
        OP_RC_SCAN: begin
          pend_v_r <= scan_issue;
          if (scan_issue) begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
          if (pend_v_r && (ram_rdata == '0)) begin
            free_r <= free_r + 1'b1;
          end
        end
        OP_WR_COMMIT: begin
          if ((ram_rdata == '0) && (value_r != '0)) begin
            free_r <= free_r - 1'b1;
          end else if ((ram_rdata != '0) && (value_r == '0)) begin
            free_r <= free_r + 1'b1;
          end
        end
        OP_AL_SCAN: begin
          pend_v_r <= scan_issue;
          if (scan_issue) begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
          if (found) begin
            free_r <= free_r - 1'b1;
          end
        end
        OP_AL_FINAL: begin
          if (have_prev_r && (end_mark_r == '0)) begin
            free_r <= free_r + 1'b1;
          end
        end
        default: begin
          pend_v_r <= pend_v_r;
        end
      endcase
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      target_r <= in_target_cluster;
      value_r  <= in_entry_value;
      need_r   <= need_in;
    end
    if ((cmd.op == OP_RC_SCAN) || (cmd.op == OP_AL_SCAN)) begin
      pend_addr_r <= scan_addr_r[ADDR_W-1:0];
    end
    if (cmd.op == OP_DECODE) begin
      have_prev_r <= 1'b0;
      first_r     <= '0;
    end
    if (found) begin
      need_r      <= need_r - 1'b1;
      prev_r      <= pend_addr_r;
      have_prev_r <= 1'b1;
      if (!have_prev_r) begin
        first_r <= pend_addr_r;
      end
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.res_load) begin
      out_first_r  <= FIRST_W'(first_r);
      out_status_r <= status_r;
      out_free_r   <= FREE_W'(free_r);
    end
  end

  assign stat.clr_done   = (scan_addr_r[ADDR_W-1:0] == ADDR_W'(TABLE_ENTRIES - 1));
  assign stat.scan_end   = !scan_issue && !pend_v_r;
  assign stat.need_zero  = (need_r == '0);
  assign stat.is_write   = (action_r == ACT_WRITE);
  assign stat.bad_target = (32'(target_r) < FIRST_DATA) || (32'(target_r) >= 32'(lim));
  assign stat.no_space   = (32'(need_r) > 32'(free_r));
  assign stat.out_ready  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_first_cluster = out_first_r;
  assign out_status        = out_status_r;
  assign out_free_clusters = out_free_r;

  a_link_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (found && have_prev_r) |-> (prev_r < pend_addr_r))
    else $error("chain link does not point forward");

  a_scan_enough: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_AL_SCAN) && stat.scan_end) |-> (need_r == '0))
    else $error("scan ended before the chain was complete");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

endmodule

[sv/fca_ctrl.sv]
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator controller
// Sequences the table clearing pass, free count recounts and the handling
// of each request.
// ----------------------------------------------------------------------------
module fca_ctrl import fca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  fca_stat_t              stat,
  output fca_cmd_t               cmd
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_RC_INIT   = 4'd2;
  localparam logic [3:0] S_RC_SCAN   = 4'd3;
  localparam logic [3:0] S_DECODE    = 4'd4;
  localparam logic [3:0] S_WR_COMMIT = 4'd5;
  localparam logic [3:0] S_AL_SCAN   = 4'd6;
  localparam logic [3:0] S_AL_FINAL  = 4'd7;
  localparam logic [3:0] S_RESULT    = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       pend_r;
  logic       pend_nxt;

  assign in_stall = (state_r != S_IDLE) || pend_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pend_r) begin
          state_nxt = S_RC_INIT;
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_RC_INIT: begin
        cmd.op    = OP_RC_INIT;
        state_nxt = S_RC_SCAN;
      end
      S_RC_SCAN: begin
        cmd.op = OP_RC_SCAN;
        if (stat.scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_DECODE: begin
        cmd.op         = OP_DECODE;
        cmd.set_status = 1'b1;
        if (stat.is_write) begin
          if (stat.bad_target) begin
            cmd.status = ST_BAD_CLUSTER;
            state_nxt  = S_RESULT;
          end else begin
            cmd.status = ST_DONE;
            state_nxt  = S_WR_COMMIT;
          end
        end else if (stat.need_zero) begin
          cmd.status = ST_ZERO_LEN;
          state_nxt  = S_RESULT;
        end else if (stat.no_space) begin
          cmd.status = ST_NO_SPACE;
          state_nxt  = S_RESULT;
        end else begin
          cmd.status = ST_DONE;
          state_nxt  = S_AL_SCAN;
        end
      end
      S_WR_COMMIT: begin
        cmd.op    = OP_WR_COMMIT;
        state_nxt = S_RESULT;
      end
      S_AL_SCAN: begin
        cmd.op = OP_AL_SCAN;
        if (stat.need_zero || stat.scan_end) begin
          state_nxt = S_AL_FINAL;
        end
      end
      S_AL_FINAL: begin
        cmd.op    = OP_AL_FINAL;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A change of the active count leaves the free count stale until recounted.
  always_comb begin
    pend_nxt = pend_r;
    if (cfg_we && (cfg_index == REG_ACTIVE)) begin
      pend_nxt = 1'b1;
    end else if (((state_r == S_CLEAR) && stat.clr_done) || (state_r == S_RC_INIT)) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AL_FINAL) |=> (state_r == S_RESULT))
    else $error("chain finish not followed by result");

endmodule

[sv/fat12_cluster_chain_allocator.sv]
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator
// Keeps a table of 12-bit allocation entries, allocates chains of the lowest
// free clusters and writes single entries on request.
// ----------------------------------------------------------------------------
// A write request passes through the decode, commit and result states;
// refused, zero-length and no-space requests go from decode to the result state.
// An allocation scans the table one entry per cycle through the single read
// port until the chain is complete or the active clusters are exhausted.
// One request is handled at a time; the next is taken once the result is
// registered, even while that result is still held by a stall.
// After reset a clearing pass zeroes all 2048 table entries, and each
// write of active_clusters triggers a recount of the free clusters.
module fat12_cluster_chain_allocator import fca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [BYTES_W-1:0]     in_byte_count,
  input  logic [TARGET_W-1:0]    in_target_cluster,
  input  logic [ENTRY_W-1:0]     in_entry_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIRST_W-1:0]     out_first_cluster,
  output logic [STATUS_W-1:0]    out_status,
  output logic [FREE_W-1:0]      out_free_clusters,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  fca_cmd_t  cmd;
  fca_stat_t stat;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .stat      (stat),
    .cmd       (cmd)
  );

  fca_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_byte_count     (in_byte_count),
    .in_target_cluster (in_target_cluster),
    .in_entry_value    (in_entry_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_cluster (out_first_cluster),
    .out_status        (out_status),
    .out_free_clusters (out_free_clusters)
  );

endmodule
